### hdl/csvp_pkg.sv
// Shared constants and types for the comma-separated integer list parser.
// Holds character codes, status codes and the flag bundle passed core-to-top.
// No dependencies.
package csvp_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result status codes
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_MANY = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_OVER = 2'd3;

    // Width of the max_values register
    localparam int MAXV_BITS = 16;
    localparam logic [MAXV_BITS-1:0] MAXV_RESET = 16'hFFFF;

    // Result flags from the parse core
    typedef struct packed {
        logic                   emit;
        logic [STATUS_BITS-1:0] status;
        logic                   last;
    } csvp_flags_t;

endpackage

### hdl/comma_separated_int_list_parser.sv
// Top level of the comma-separated signed decimal integer list parser.
// Depends on csvp_pkg and csvp_core; holds the input and result registers.
//
// The block takes one text byte per cycle, back to back, save for output stalls, and
// returns one word for each comma or NUL that ends a field (none while text after
// an error is skipped up to its NUL). A byte enters the input register, is processed
// from there by the multiply-by-ten-and-add on the magnitude register, and its
// result lands in the output register.
// A waiting result does not stop input until a second result is due.
// max_values may be written only while the block is idle.
module comma_separated_int_list_parser
    import csvp_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [MAXV_BITS-1:0] cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] char_code
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((VALUE_BITS+COUNT_BITS+STATUS_BITS+7)/8)*8-1:0] m_tdata,
                                            // value, value_count, status
    output logic                 m_tlast    // last
);

    localparam int TDATA_W = ((VALUE_BITS + COUNT_BITS + STATUS_BITS + 7) / 8) * 8;

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic [MAXV_BITS-1:0]  max_values_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic                  out_last_reg;

    csvp_flags_t           flags;
    logic [VALUE_BITS-1:0] core_value;
    logic [COUNT_BITS-1:0] core_count;
    logic                  advance;

    // Advance when the byte produces no word or the output slot is free
    assign advance  = in_valid_reg && (!flags.emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    csvp_core #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .char_code   (in_char_reg),
        .max_values  (max_values_reg),
        .flags       (flags),
        .value       (core_value),
        .value_count (core_count)
    );

    // Control: input slot, output slot, configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_values_reg <= MAXV_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && flags.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                max_values_reg <= cfg_wdata;
            end
        end
    end

    // Payload: capture input byte, load result word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
        if (advance && flags.emit) begin
            out_value_reg  <= core_value;
            out_count_reg  <= core_count;
            out_status_reg <= flags.status;
            out_last_reg   <= flags.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_status_reg, out_count_reg, out_value_reg});
    assign m_tlast  = out_last_reg;

endmodule

### hdl/csvp_core.sv
// Parse core: field and list state plus the per-character update logic.
// Depends on csvp_pkg. Results are combinational from state and the
// current character; state advances when step_en is high.
module csvp_core
    import csvp_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            char_code,
    input  logic [MAXV_BITS-1:0]  max_values,
    output csvp_flags_t           flags,
    output logic [VALUE_BITS-1:0] value,
    output logic [COUNT_BITS-1:0] value_count
);

    localparam int MW    = VALUE_BITS + 4;
    localparam int CAP_W = (COUNT_BITS > MAXV_BITS) ? COUNT_BITS : MAXV_BITS;
    localparam logic [MW-1:0] LIMIT = MW'(1) << (VALUE_BITS - 1);
    localparam logic [CAP_W-1:0] FULL_COUNT = CAP_W'({COUNT_BITS{1'b1}});

    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   started_reg, started_next;
    logic [STATUS_BITS-1:0] ferr_reg, ferr_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   drop_reg, drop_next;

    logic [MW-1:0]          mag_x10;
    logic [CAP_W-1:0]       max_ext;
    logic [CAP_W-1:0]       cap;
    logic [STATUS_BITS-1:0] term_err;
    logic                   is_term;

    // Multiply by ten and add the digit, with headroom for the overflow check
    assign mag_x10 = (MW'(mag_reg) << 3) + (MW'(mag_reg) << 1) + MW'(char_code[3:0]);

    // Count limit: max_values, clipped to what the counter holds
    assign max_ext = CAP_W'(max_values);
    assign cap     = (max_ext < FULL_COUNT) ? max_ext : FULL_COUNT;

    assign is_term = (char_code == CH_COMMA) || (char_code == CH_NUL);

    always_comb begin
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        ferr_next    = ferr_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        flags        = '0;
        value        = '0;
        value_count  = count_reg;
        term_err     = ferr_reg;

        if (drop_reg) begin
            // drop text until NUL, then start a fresh list
            if (char_code == CH_NUL) begin
                mag_next     = '0;
                neg_next     = 1'b0;
                started_next = 1'b0;
                ferr_next    = ST_OK;
                count_next   = '0;
                drop_next    = 1'b0;
            end
        end else if (!is_term) begin
            // accumulate a field character; first error wins
            if (ferr_reg == ST_OK) begin
                if (char_code inside {[CH_ZERO:CH_NINE]}) begin
                    if (mag_x10 > LIMIT) begin
                        ferr_next = ST_OVER;
                    end else begin
                        mag_next = mag_x10[VALUE_BITS-1:0];
                    end
                end else if (!started_reg && char_code == CH_MINUS) begin
                    neg_next = 1'b1;
                end else begin
                    ferr_next = ST_BAD;
                end
            end
            started_next = 1'b1;
        end else begin
            // close the field: positive magnitude at the limit overflows
            if (ferr_reg == ST_OK && !neg_reg && mag_reg[VALUE_BITS-1]) begin
                term_err = ST_OVER;
            end
            flags.emit = 1'b1;
            if (term_err != ST_OK) begin
                flags.status = term_err;
            end else if (CAP_W'(count_reg) >= cap) begin
                flags.status = ST_MANY;
            end else begin
                flags.status = ST_OK;
            end

            mag_next     = '0;
            neg_next     = 1'b0;
            started_next = 1'b0;
            ferr_next    = ST_OK;

            if (flags.status == ST_OK) begin
                value       = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
                value_count = count_reg + 1'b1;
                flags.last  = (char_code == CH_NUL);
                count_next  = (char_code == CH_NUL) ? '0 : count_reg + 1'b1;
            end else begin
                flags.last = 1'b1;
                if (char_code == CH_NUL) begin
                    count_next = '0;
                end else begin
                    drop_next = 1'b1;
                end
            end
        end
    end

    // Hold state, advance on step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            ferr_reg    <= ST_OK;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
        end else if (step_en) begin
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            ferr_reg    <= ferr_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
        end
    end

endmodule
